@@ rtl/core/b32d_pkg.sv @@
`default_nettype none
package b32d_pkg;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_DASH  = 8'h2D;
  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_ONE   = 8'h31;
  localparam logic [7:0] CHAR_TWO   = 8'h32;
  localparam logic [7:0] CHAR_SEVEN = 8'h37;
  localparam logic [7:0] CHAR_EIGHT = 8'h38;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_B  = 8'h42;
  localparam logic [7:0] CHAR_UP_L  = 8'h4C;
  localparam logic [7:0] CHAR_UP_O  = 8'h4F;
  localparam logic [7:0] CHAR_UP_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7A;
  localparam logic [7:0] SYM_MASK   = 8'h1F;
  localparam logic [7:0] DIGIT_BIAS = 8'd24;

  localparam logic [15:0] MAX_BYTES_RESET = 16'hFFFF;

  localparam int QUEUE_DEPTH = 2;
  localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    CLS_NUL,
    CLS_PAD,
    CLS_SKIP,
    CLS_SYM,
    CLS_BAD
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [4:0] sym;
  } entry_t;

  typedef struct packed {
    logic   empty;
    entry_t entry;
  } q_status_t;

endpackage
`default_nettype wire

@@ rtl/core/b32d_front.sv @@
`default_nettype none
module b32d_front
  import b32d_pkg::*;
(
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] char_in,
  input  wire logic       q_full,
  output logic            push,
  output entry_t          push_entry
);

  logic [7:0] c;
  logic [7:0] sym_wide;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    priority if (char_in == CHAR_ZERO) begin
      c = CHAR_UP_O;
    end else if (char_in == CHAR_ONE) begin
      c = CHAR_UP_L;
    end else if (char_in == CHAR_EIGHT) begin
      c = CHAR_UP_B;
    end else begin
      c = char_in;
    end
  end

  always_comb begin
    sym_wide = 8'd0;
    priority if (char_in == CHAR_NUL) begin
      push_entry.cls = CLS_NUL;
    end else if (char_in == CHAR_PAD) begin
      push_entry.cls = CLS_PAD;
    end else if (char_in == CHAR_SPACE || char_in == CHAR_TAB || char_in == CHAR_CR ||
                 char_in == CHAR_LF || char_in == CHAR_DASH) begin
      push_entry.cls = CLS_SKIP;
    end else if ((c >= CHAR_UP_A && c <= CHAR_UP_Z) || (c >= CHAR_LO_A && c <= CHAR_LO_Z)) begin
      push_entry.cls = CLS_SYM;
      sym_wide = (c & SYM_MASK) - 8'd1;
    end else if (c >= CHAR_TWO && c <= CHAR_SEVEN) begin
      push_entry.cls = CLS_SYM;
      sym_wide = c - DIGIT_BIAS;
    end else begin
      push_entry.cls = CLS_BAD;
    end
    push_entry.sym = sym_wide[4:0];
  end

endmodule
`default_nettype wire

@@ rtl/core/b32d_queue.sv @@
`default_nettype none
module b32d_queue
  import b32d_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  entry_t      push_entry,
  input  wire logic   pop,
  output logic        full,
  output q_status_t   status
);

  entry_t             slots [QUEUE_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign full         = (count == Q_CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign status.entry = slots[rd_ptr];
  assign do_push      = push && !full;
  assign do_pop       = pop && !status.empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - Q_CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/b32d_back.sv @@
`default_nettype none
module b32d_back
  import b32d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        max_output_bytes_we,
  input  wire logic [15:0] max_output_bytes,
  input  q_status_t        status,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       data_byte,
  output logic [15:0]      byte_count
);

  logic [15:0] max_bytes;
  logic [11:0] bit_accumulator;
  logic [3:0]  bits_held;
  logic [15:0] bytes_out;
  logic        stopped;
  logic        error_seen;

  logic [11:0] acc_next;
  logic [3:0]  held_sum;
  logic [3:0]  shift;
  logic [11:0] shifted;

  assign pop      = !status.empty && (!out_valid || !out_stall);
  assign acc_next = {bit_accumulator[6:0], status.entry.sym};
  assign held_sum = bits_held + 4'd5;
  assign shift    = held_sum - 4'd8;
  assign shifted  = acc_next >> shift;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_bytes       <= MAX_BYTES_RESET;
      bit_accumulator <= '0;
      bits_held       <= '0;
      bytes_out       <= '0;
      stopped         <= 1'b0;
      error_seen      <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (max_output_bytes_we) begin
        max_bytes <= max_output_bytes;
      end
      if (!pop && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        priority if (status.entry.cls == CLS_NUL) begin
          out_valid <= !error_seen;
          if (!error_seen) begin
            kind       <= KIND_END;
            data_byte  <= '0;
            byte_count <= bytes_out;
          end
          bit_accumulator <= '0;
          bits_held       <= '0;
          bytes_out       <= '0;
          stopped         <= 1'b0;
          error_seen      <= 1'b0;
        end else if (error_seen || stopped) begin
          out_valid <= 1'b0;
        end else if (bytes_out >= max_bytes || status.entry.cls == CLS_PAD) begin
          out_valid <= 1'b0;
          stopped   <= 1'b1;
        end else if (status.entry.cls == CLS_BAD) begin
          error_seen <= 1'b1;
          out_valid  <= 1'b1;
          kind       <= KIND_ERROR;
          data_byte  <= '0;
          byte_count <= '0;
        end else if (status.entry.cls == CLS_SYM) begin
          bit_accumulator <= acc_next;
          if (held_sum >= 4'd8) begin
            bits_held  <= shift;
            bytes_out  <= bytes_out + 16'd1;
            out_valid  <= 1'b1;
            kind       <= KIND_BYTE;
            data_byte  <= shifted[7:0];
            byte_count <= '0;
          end else begin
            out_valid <= 1'b0;
            bits_held <= held_sum;
          end
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/base32_lenient_decoder.sv @@
`default_nettype none
// Lenient base32 decoder that takes one character per transfer and returns decoded bytes,
// an end-of-string count on NUL, or one error per string for an invalid character. It
// accepts one character every cycle while the queue is not full, and delivers at most
// one result per character, registered after its character leaves the queue. A two-entry
// queue sits between the character classifier and the decode state and takes new
// characters while a result still waits, so a stalled output only stops input
// once the queue is full.
module base32_lenient_decoder
  import b32d_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        max_output_bytes_we,
  input  wire logic [15:0] max_output_bytes,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  char_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       data_byte,
  output logic [15:0]      byte_count
);

  logic      q_full;
  logic      push;
  entry_t    push_entry;
  logic      pop;
  q_status_t status;

  b32d_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_in    (char_in),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  b32d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .status     (status)
  );

  b32d_back u_back (
    .clk                 (clk),
    .rst                 (rst),
    .max_output_bytes_we (max_output_bytes_we),
    .max_output_bytes    (max_output_bytes),
    .status              (status),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .kind                (kind),
    .data_byte           (data_byte),
    .byte_count          (byte_count)
  );

`ifndef SYNTHESIS
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (kind == KIND_BYTE || kind == KIND_END || kind == KIND_ERROR))
    else $error("result kind out of range");

  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_BYTE) |-> (data_byte == 8'd0))
    else $error("data byte not zero on a non-byte result");

  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind != KIND_END) |-> (byte_count == 16'd0))
    else $error("byte count not zero on a non-end result");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule
`default_nettype wire

@@ test/tb_base32_lenient_decoder.sv @@
`timescale 1ns / 1ps
module tb_base32_lenient_decoder;
  import b32d_pkg::*;

  typedef struct {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [15:0] count;
  } decode_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        max_output_bytes_we = 1'b0;
  logic [15:0] max_output_bytes = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_in = 8'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] byte_count;

  logic [7:0]     char_q[$];
  decode_result_t pending_results[$];
  int             errors = 0;
  logic           char_taken = 1'b0;
  int             burst_left = 0;
  int             gap_left = 0;
  logic [15:0]    stall_pat = 16'd0;
  int             stall_left = 0;

  logic [15:0] limit;
  logic [11:0] acc;
  logic [3:0]  held;
  logic [15:0] nbytes;
  logic        stopped;
  logic        err_seen;

  base32_lenient_decoder dut (
    .clk                 (clk),
    .rst                 (rst),
    .max_output_bytes_we (max_output_bytes_we),
    .max_output_bytes    (max_output_bytes),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .char_in             (char_in),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .kind                (kind),
    .data_byte           (data_byte),
    .byte_count          (byte_count)
  );

  always #5 clk = ~clk;

  function automatic int symbol_of(logic [7:0] c);
    logic [7:0] ch;
    ch = c;
    if (ch == CHAR_ZERO) ch = CHAR_UP_O;
    else if (ch == CHAR_ONE) ch = CHAR_UP_L;
    else if (ch == CHAR_EIGHT) ch = CHAR_UP_B;
    if ((ch >= CHAR_UP_A && ch <= CHAR_UP_Z) || (ch >= CHAR_LO_A && ch <= CHAR_LO_Z))
      return int'(ch & SYM_MASK) - 1;
    if (ch >= CHAR_TWO && ch <= CHAR_SEVEN)
      return int'(ch - DIGIT_BIAS);
    return -1;
  endfunction

  function automatic logic is_skip(logic [7:0] c);
    return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_CR || c == CHAR_LF ||
           c == CHAR_DASH;
  endfunction

  function automatic logic is_bad(logic [7:0] c);
    return c != CHAR_NUL && c != CHAR_PAD && !is_skip(c) && symbol_of(c) < 0;
  endfunction

  task automatic push_result(logic [1:0] k, logic [7:0] d, logic [15:0] n);
    decode_result_t r;
    r.kind = k;
    r.data = d;
    r.count = n;
    pending_results.push_back(r);
  endtask

  task automatic clear_string();
    acc = '0;
    held = '0;
    nbytes = '0;
    stopped = 1'b0;
    err_seen = 1'b0;
  endtask

  task automatic decode_char(logic [7:0] c);
    int          v;
    logic [11:0] shifted;
    logic [15:0] n;
    if (c == CHAR_NUL) begin
      n = nbytes;
      if (!err_seen) push_result(KIND_END, 8'd0, n);
      clear_string();
    end else if (err_seen || stopped) begin
    end else if (nbytes >= limit || c == CHAR_PAD) begin
      stopped = 1'b1;
    end else if (!is_skip(c)) begin
      v = symbol_of(c);
      if (v < 0) begin
        err_seen = 1'b1;
        push_result(KIND_ERROR, 8'd0, 16'd0);
      end else begin
        acc = {acc[6:0], 5'(v)};
        held = held + 4'd5;
        if (held >= 4'd8) begin
          shifted = acc >> (held - 4'd8);
          held = held - 4'd8;
          nbytes = nbytes + 16'd1;
          push_result(KIND_BYTE, shifted[7:0], 16'd0);
        end
      end
    end
  endtask

  // Checks result transfers and predicts from character transfers.
  always @(posedge clk) begin
    decode_result_t want;
    char_taken = 1'b0;
    if (rst) begin
      limit = MAX_BYTES_RESET;
      clear_string();
      pending_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with none expected: kind %0d data %0h count %0d",
                   $time, kind, data_byte, byte_count);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (kind !== want.kind) begin
            $display("%0t: kind expected %0d, got %0d", $time, want.kind, kind);
            errors++;
          end
          if (data_byte !== want.data) begin
            $display("%0t: data_byte expected %0h, got %0h", $time, want.data, data_byte);
            errors++;
          end
          if (byte_count !== want.count) begin
            $display("%0t: byte_count expected %0d, got %0d", $time, want.count,
                     byte_count);
            errors++;
          end
        end
      end
      if (max_output_bytes_we) limit = max_output_bytes;
      if (in_valid && !in_stall) begin
        char_taken = 1'b1;
        decode_char(char_in);
      end
    end
  end

  // The sender works in bursts with gaps between some of them.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || char_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (char_q.size() > 0) begin
        char_in <= char_q.pop_front();
        in_valid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver stalls on a rotating pattern that is replaced now and then.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(8, 64);
      case ($urandom_range(0, 3))
        0: stall_pat = 16'd0;
        1: stall_pat = 16'($urandom);
        2: stall_pat = 16'($urandom) & 16'($urandom);
        default: stall_pat = 16'($urandom) | 16'($urandom);
      endcase
      if (stall_pat == 16'hFFFF) stall_pat[0] = 1'b0;
    end else begin
      stall_left--;
    end
    stall_pat = {stall_pat[0], stall_pat[15:1]};
    out_stall <= stall_pat[0];
  end

  function automatic logic [7:0] rand_symbol_char();
    case ($urandom_range(0, 5))
      0, 1: return 8'(CHAR_UP_A + $urandom_range(0, 25));
      2: return 8'(CHAR_LO_A + $urandom_range(0, 25));
      3, 4: return 8'(CHAR_TWO + $urandom_range(0, 5));
      default: begin
        case ($urandom_range(0, 2))
          0: return CHAR_ZERO;
          1: return CHAR_ONE;
          default: return CHAR_EIGHT;
        endcase
      end
    endcase
  endfunction

  function automatic logic [7:0] rand_skip_char();
    case ($urandom_range(0, 4))
      0: return CHAR_SPACE;
      1: return CHAR_TAB;
      2: return CHAR_CR;
      3: return CHAR_LF;
      default: return CHAR_DASH;
    endcase
  endfunction

  function automatic logic [7:0] rand_bad_char();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255)); while (!is_bad(c));
    return c;
  endfunction

  task automatic push_symbols(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 7) == 0) char_q.push_back(rand_skip_char());
      char_q.push_back(rand_symbol_char());
    end
  endtask

  task automatic push_string();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    push_symbols(n);
    case ($urandom_range(0, 11))
      0, 1: begin
        char_q.push_back(rand_bad_char());
        push_symbols($urandom_range(0, 4));
      end
      2, 3: begin
        char_q.push_back(CHAR_PAD);
        if ($urandom_range(0, 1) == 0) char_q.push_back(CHAR_PAD);
        push_symbols($urandom_range(0, 3));
      end
      4: begin
        for (int i = $urandom_range(1, 6); i > 0; i--)
          char_q.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    char_q.push_back(CHAR_NUL);
  endtask

  task automatic wait_idle();
    while (char_q.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_limit(logic [15:0] v);
    @(negedge clk);
    max_output_bytes_we <= 1'b1;
    max_output_bytes <= v;
    @(negedge clk);
    max_output_bytes_we <= 1'b0;
  endtask

  initial begin
    logic [15:0] limits[8];
    int          targets[8];
    limits = '{16'hFFFF, 16'd0, 16'd1, 16'd5, 16'($urandom_range(2, 40)), 16'hFFFF,
               16'($urandom), 16'd2};
    targets = '{240, 60, 180, 200, 220, 240, 240, 200};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    write_limit(16'hFFFF);

    char_q = '{"M", "Z", "x", "w", "6", "1", "0", "8", CHAR_SPACE, CHAR_TAB, CHAR_CR,
               CHAR_LF, CHAR_DASH, "2", "7", "7", CHAR_PAD, "A", CHAR_NUL,
               "A", 8'hFF, "B", CHAR_NUL, "A", "A", "A", "A"};
    wait_idle();
    // The string stays open across this write; the new limit stops it at once.
    write_limit(16'd2);
    char_q = '{"A", "A", CHAR_NUL};
    wait_idle();
    write_limit(16'd0);
    char_q = '{"A", "B", 8'h80, CHAR_NUL};
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      write_limit(limits[p]);
      while (char_q.size() < targets[p]) begin
        if ($urandom_range(0, 9) == 0) begin
          for (int i = $urandom_range(1, 6); i > 0; i--)
            char_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          push_string();
        end
      end
      char_q.push_back(CHAR_NUL);
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (errors == 0) $display("** base32_lenient_decoder: PASSED **");
    else $display("** base32_lenient_decoder: FAILED **");
    $finish;
  end

  initial begin
    #5000000;
    $display("** base32_lenient_decoder: FAILED **");
    $finish;
  end

endmodule
